@@ hw/rtl/xmcrc_pkg.sv @@
// Shared types, constants and the CRC function of the XMODEM-1K receiver
`timescale 1ns / 1ps

package xmcrc_pkg;

  // block sizes and frame counter width
  localparam int unsigned LARGE_BLOCK_BYTES = 1024;
  localparam int unsigned SMALL_BLOCK_BYTES = 128;
  localparam int unsigned FRAME_IDX_W       = $clog2(LARGE_BLOCK_BYTES + 4);

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 32;
  localparam int unsigned CRC_W    = 16;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'b1;

  localparam logic [BYTE_W-1:0] RETRY_LIMIT_RESET = 8'd25;

  // request opcodes
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_BYTE    = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd2;

  // end status codes
  localparam logic [STATUS_W-1:0] STATUS_EOT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_CANCEL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FAIL   = 2'd2;

  // line protocol bytes
  localparam logic [BYTE_W-1:0] CH_SOH = 8'h01;
  localparam logic [BYTE_W-1:0] CH_STX = 8'h02;
  localparam logic [BYTE_W-1:0] CH_EOT = 8'h04;
  localparam logic [BYTE_W-1:0] CH_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CH_NAK = 8'h15;
  localparam logic [BYTE_W-1:0] CH_CAN = 8'h18;
  localparam logic [BYTE_W-1:0] CH_C   = 8'h43;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // receiver phase
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_FRAME,
    PH_DRAIN
  } phase_e;

  // group of results caused by one request
  typedef enum logic [1:0] {
    BK_TX,      // one transmit byte
    BK_STORE,   // one payload store
    BK_FINISH,  // ACK then finished
    BK_ABORT    // NAK, three CAN, then finished with failure
  } bundle_kind_e;

  typedef struct packed {
    bundle_kind_e          kind;
    logic [BYTE_W-1:0]     tx_byte;
    logic [ADDR_W-1:0]     store_address;
    logic [BYTE_W-1:0]     store_byte;
    logic [STATUS_W-1:0]   end_status;
    logic [LEN_W-1:0]      total_length;
  } bundle_t;

  // crc-16-ccitt, msb first, one byte
  function automatic logic [CRC_W-1:0] crc16_update(logic [CRC_W-1:0] crc,
                                                    logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/xmcrc_if.sv @@
// Request and result channel interfaces of the XMODEM-1K receiver
`timescale 1ns / 1ps

interface xmcrc_item_if;
  import xmcrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface xmcrc_result_if;
  import xmcrc_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   tx_byte;
  logic [ADDR_W-1:0]   store_address;
  logic [BYTE_W-1:0]   store_byte;
  logic [STATUS_W-1:0] end_status;
  logic [LEN_W-1:0]    total_length;
  logic                last;

  modport source (output valid, output kind, output tx_byte, output store_address,
                  output store_byte, output end_status, output total_length,
                  output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input store_address,
                  input store_byte, input end_status, input total_length,
                  input last, output ready);
endinterface

@@ hw/rtl/xmcrc_engine.sv @@
// Protocol engine: config registers, frame parser, crc check and result bundles
`timescale 1ns / 1ps

module xmcrc_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [xmcrc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [xmcrc_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                               accept_i,
  input  logic [xmcrc_pkg::OP_W-1:0]         op_i,
  input  logic [xmcrc_pkg::BYTE_W-1:0]       rx_byte_i,
  output logic                               push_o,
  output xmcrc_pkg::bundle_t                 bundle_o
);
  import xmcrc_pkg::*;

  // configuration
  logic [ADDR_W-1:0] dest_base_q;
  logic [BYTE_W-1:0] retry_limit_q;

  // protocol state
  phase_e                 phase_q, phase_d;
  logic [BYTE_W-1:0]      expected_q, expected_d;
  logic                   large_q, large_d;
  logic [FRAME_IDX_W-1:0] fidx_q, fidx_d;
  logic [BYTE_W-1:0]      seq_q, seq_d;
  logic [BYTE_W-1:0]      seq_cmp_q, seq_cmp_d;
  logic [CRC_W-1:0]       crc_q, crc_d;
  logic [BYTE_W-1:0]      crc_hi_q, crc_hi_d;
  logic [LEN_W-1:0]       acc_len_q, acc_len_d;
  logic [BYTE_W-1:0]      retries_q, retries_d;
  logic [BYTE_W-1:0]      reply_q, reply_d;
  logic [ADDR_W-1:0]      offset_q, offset_d;

  logic                   do_prompt;
  logic [FRAME_IDX_W-1:0] blk;
  logic [FRAME_IDX_W-1:0] crc_hi_idx;
  logic                   seq_pair_ok;
  logic                   seq_ok;
  logic                   crc_ok;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_base_q   <= '0;
      retry_limit_q <= RETRY_LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_DEST_BASE:   dest_base_q   <= cfg_wdata_i[ADDR_W-1:0];
        REG_RETRY_LIMIT: retry_limit_q <= cfg_wdata_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  // frame checks
  assign blk         = large_q ? FRAME_IDX_W'(LARGE_BLOCK_BYTES)
                               : FRAME_IDX_W'(SMALL_BLOCK_BYTES);
  assign crc_hi_idx  = blk + FRAME_IDX_W'(2);
  assign seq_pair_ok = ({1'b0, seq_q} + {1'b0, seq_cmp_q}) == 9'h0FF;
  assign seq_ok      = (seq_q == expected_q) || (seq_q == expected_q - 8'd1);
  assign crc_ok      = {crc_hi_q, rx_byte_i} == crc_q;

  // next state and result bundle
  always_comb begin
    phase_d   = phase_q;
    expected_d = expected_q;
    large_d   = large_q;
    fidx_d    = fidx_q;
    seq_d     = seq_q;
    seq_cmp_d = seq_cmp_q;
    crc_d     = crc_q;
    crc_hi_d  = crc_hi_q;
    acc_len_d = acc_len_q;
    retries_d = retries_q;
    reply_d   = reply_q;
    offset_d  = offset_q;
    do_prompt = 1'b0;
    push_o    = 1'b0;
    bundle_o  = '0;

    if (accept_i) begin
      case (op_i)
        OP_START: begin
          expected_d = 8'd1;
          acc_len_d  = '0;
          retries_d  = retry_limit_q;
          reply_d    = CH_C;
          fidx_d     = '0;
          do_prompt  = 1'b1;
        end
        OP_BYTE: begin
          case (phase_q)
            PH_HEADER: begin
              if (rx_byte_i == CH_SOH || rx_byte_i == CH_STX) begin
                large_d  = (rx_byte_i == CH_STX);
                fidx_d   = '0;
                crc_d    = '0;
                offset_d = acc_len_q;
                phase_d  = PH_FRAME;
              end else if (rx_byte_i == CH_EOT) begin
                push_o                = 1'b1;
                bundle_o.kind         = BK_FINISH;
                bundle_o.end_status   = STATUS_EOT;
                bundle_o.total_length = acc_len_q;
                phase_d               = PH_IDLE;
              end else if (rx_byte_i == CH_CAN) begin
                push_o              = 1'b1;
                bundle_o.kind       = BK_FINISH;
                bundle_o.end_status = STATUS_CANCEL;
                phase_d             = PH_IDLE;
              end else begin
                do_prompt = 1'b1;
              end
            end
            PH_FRAME: begin
              fidx_d = fidx_q + FRAME_IDX_W'(1);
              if (fidx_q == '0) begin
                seq_d = rx_byte_i;
              end else if (fidx_q == FRAME_IDX_W'(1)) begin
                seq_cmp_d = rx_byte_i;
              end else if (fidx_q < crc_hi_idx) begin
                // payload byte
                crc_d    = crc16_update(crc_q, rx_byte_i);
                offset_d = offset_q + ADDR_W'(1);
                if (seq_q == expected_q) begin
                  push_o                 = 1'b1;
                  bundle_o.kind          = BK_STORE;
                  bundle_o.store_address = dest_base_q + offset_q;
                  bundle_o.store_byte    = rx_byte_i;
                end
              end else if (fidx_q == crc_hi_idx) begin
                crc_hi_d = rx_byte_i;
              end else begin
                // crc low byte closes the frame
                fidx_d = '0;
                if (seq_pair_ok && crc_ok && seq_ok) begin
                  if (seq_q == expected_q) begin
                    acc_len_d  = acc_len_q + LEN_W'(blk);
                    expected_d = expected_q + 8'd1;
                    retries_d  = retry_limit_q;
                  end
                  reply_d   = CH_ACK;
                  do_prompt = 1'b1;
                end else begin
                  reply_d = CH_NAK;
                  phase_d = PH_DRAIN;
                end
              end
            end
            default: ;
          endcase
        end
        OP_TIMEOUT: begin
          case (phase_q)
            PH_HEADER, PH_DRAIN: do_prompt = 1'b1;
            PH_FRAME: begin
              fidx_d    = '0;
              reply_d   = CH_NAK;
              do_prompt = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end

    // prompt the sender or give up
    if (do_prompt) begin
      push_o = 1'b1;
      if (retries_d == '0) begin
        bundle_o.kind       = BK_ABORT;
        bundle_o.end_status = STATUS_FAIL;
        phase_d             = PH_IDLE;
      end else begin
        retries_d        = retries_d - 8'd1;
        bundle_o.kind    = BK_TX;
        bundle_o.tx_byte = reply_d;
        phase_d          = PH_HEADER;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      expected_q <= 8'd1;
      large_q    <= 1'b0;
      fidx_q     <= '0;
      seq_q      <= '0;
      seq_cmp_q  <= '0;
      crc_q      <= '0;
      crc_hi_q   <= '0;
      acc_len_q  <= '0;
      retries_q  <= RETRY_LIMIT_RESET;
      reply_q    <= CH_C;
      offset_q   <= '0;
    end else begin
      phase_q    <= phase_d;
      expected_q <= expected_d;
      large_q    <= large_d;
      fidx_q     <= fidx_d;
      seq_q      <= seq_d;
      seq_cmp_q  <= seq_cmp_d;
      crc_q      <= crc_d;
      crc_hi_q   <= crc_hi_d;
      acc_len_q  <= acc_len_d;
      retries_q  <= retries_d;
      reply_q    <= reply_d;
      offset_q   <= offset_d;
    end
  end

  // frame counter never runs past the crc low byte
  a_fidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_FRAME |-> fidx_q <= FRAME_IDX_W'(LARGE_BLOCK_BYTES + 3))
    else $error("frame index past end of frame");

  // a start with a nonzero budget always leaves the block awaiting a header
  a_start_prompts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && op_i == OP_START && retry_limit_q != '0 |=> phase_q == PH_HEADER)
    else $error("start did not prompt");

  // idle ignores everything but start
  a_idle_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == PH_IDLE && op_i != OP_START |-> !push_o)
    else $error("result produced while idle");

  // only a frame close changes the committed length upward
  a_len_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_len_d != acc_len_q && acc_len_d != '0 |-> phase_q == PH_FRAME)
    else $error("length changed outside a frame");

endmodule

@@ hw/rtl/xmcrc_result_queue.sv @@
// Two-entry bundle queue that unrolls each bundle into single results
`timescale 1ns / 1ps

module xmcrc_result_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  xmcrc_pkg::bundle_t bundle_i,
  output logic               full_o,
  xmcrc_result_if.source     result_o
);
  import xmcrc_pkg::*;

  bundle_t      ent_q [2];
  logic         head_q, tail_q;
  logic [1:0]   cnt_q, cnt_d;
  logic [2:0]   sub_q;
  bundle_t      head;
  logic [2:0]   len;
  logic         pop;
  logic         last;

  assign head   = ent_q[head_q];
  assign full_o = (cnt_q == 2'd2);

  // results in the head bundle
  always_comb begin
    case (head.kind)
      BK_TX, BK_STORE: len = 3'd1;
      BK_FINISH:       len = 3'd2;
      BK_ABORT:        len = 3'd5;
      default:         len = 3'd1;
    endcase
  end

  assign last = (sub_q == len - 3'd1);
  assign pop  = result_o.valid && result_o.ready && last;

  // current result fields
  always_comb begin
    result_o.valid         = (cnt_q != 2'd0);
    result_o.last          = last;
    result_o.kind          = KIND_TX;
    result_o.tx_byte       = '0;
    result_o.store_address = '0;
    result_o.store_byte    = '0;
    result_o.end_status    = '0;
    result_o.total_length  = '0;
    case (head.kind)
      BK_TX: result_o.tx_byte = head.tx_byte;
      BK_STORE: begin
        result_o.kind          = KIND_STORE;
        result_o.store_address = head.store_address;
        result_o.store_byte    = head.store_byte;
      end
      BK_FINISH: begin
        if (last) begin
          result_o.kind         = KIND_DONE;
          result_o.end_status   = head.end_status;
          result_o.total_length = head.total_length;
        end else begin
          result_o.tx_byte = CH_ACK;
        end
      end
      BK_ABORT: begin
        if (last) begin
          result_o.kind       = KIND_DONE;
          result_o.end_status = head.end_status;
        end else if (sub_q == 3'd0) begin
          result_o.tx_byte = CH_NAK;
        end else begin
          result_o.tx_byte = CH_CAN;
        end
      end
      default: ;
    endcase
  end

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[tail_q] <= bundle_i;
    end
  end

  // pointers and result counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= 1'b0;
      tail_q <= 1'b0;
      cnt_q  <= 2'd0;
      sub_q  <= 3'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        tail_q <= ~tail_q;
      end
      if (pop) begin
        head_q <= ~head_q;
        sub_q  <= 3'd0;
      end else if (result_o.valid && result_o.ready) begin
        sub_q <= sub_q + 3'd1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2)
    else $error("queue occupancy out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("push into full queue");

  a_sub_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> sub_q < len)
    else $error("result counter past bundle length");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd1 |-> head_q != tail_q)
    else $error("queue pointers disagree with occupancy");

endmodule

@@ hw/rtl/xmodem_1k_crc_receiver_top.sv @@
// Top level of the XMODEM-1K CRC receiver
`timescale 1ns / 1ps

// XMODEM-1K receiver with CRC-16-CCITT. Each request (start, received byte or
// timeout) updates the protocol state as it is accepted, and the results it
// causes are queued as one bundle in a two-entry queue. Results then leave
// one per cycle on the result channel while the sink is ready, so a request
// that causes k results (k is 0 to 5; payload bytes cause at most one) holds
// the output until all k have left. The request channel stays ready as long
// as the queue has a free entry, so with an always-ready sink the block takes
// one request per cycle for all single-result traffic. Stores are tentative:
// only addresses below dest_base plus the final total_length hold good data.
module xmodem_1k_crc_receiver_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [xmcrc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [xmcrc_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  xmcrc_item_if.sink                       item_i,
  xmcrc_result_if.source                   result_o
);
  import xmcrc_pkg::*;

  logic    accept;
  logic    push;
  logic    full;
  bundle_t bundle;

  // request handshake
  assign item_i.ready = !full;
  assign accept       = item_i.valid && !full;

  // protocol engine
  xmcrc_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .op_i        (item_i.op),
    .rx_byte_i   (item_i.rx_byte),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  // result queue and serializer
  xmcrc_result_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .bundle_i (bundle),
    .full_o   (full),
    .result_o (result_o)
  );

endmodule
